[hdl/dss_pkg.sv]
// dss_pkg: shared types, widths and codes for the dependent step sequencer.
// No dependencies; used by every module of the block.
`default_nettype none
package dss_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_DONE   = 3'd2;
    localparam logic [2:0] MODE_FAIL   = 3'd3;
    localparam logic [2:0] MODE_SETNXT = 3'd4;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_SKIP  = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    typedef struct packed {
        logic       present;
        logic [6:0] value;
    } req_entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        req_entry_t       data;
    } tbl_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic             mark;
    } fail_wr_t;

endpackage
`default_nettype wire

[hdl/dss_store.sv]
// dss_store: requirement table and fail marks of the step sequencer.
// Depends on dss_pkg.
`default_nettype none
module dss_store (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dss_pkg::tbl_wr_t                  tbl_wr,
    input  wire dss_pkg::fail_wr_t                 fail_wr,
    input  wire logic [dss_pkg::IDX_W-1:0]         rd_addr,
    output dss_pkg::req_entry_t                    rd_entry,
    output logic [dss_pkg::DEPTH-1:0]              fail_marks
);

    dss_pkg::req_entry_t tbl_reg [dss_pkg::DEPTH];
    logic [dss_pkg::DEPTH-1:0] fail_reg;

    always_ff @(posedge clk)
    begin
        if (tbl_wr.en)
        begin
            tbl_reg[tbl_wr.addr] <= tbl_wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_reg <= '0;
        end
        else if (fail_wr.en)
        begin
            fail_reg[fail_wr.addr] <= fail_wr.mark;
        end
    end

    assign rd_entry   = tbl_reg[rd_addr];
    assign fail_marks = fail_reg;

endmodule
`default_nettype wire

[hdl/dss_req_unit.sv]
// dss_req_unit: resolves a step's requirement index and tests its fail mark.
// Shared by every step of a skip chain. Depends on dss_pkg.
`default_nettype none
module dss_req_unit (
    input  wire dss_pkg::req_entry_t               entry,
    input  wire logic [dss_pkg::IDX_W-1:0]         cur,
    input  wire logic [dss_pkg::DEPTH-1:0]         fail_marks,
    output logic                                   met
);

    logic [7:0] sum;
    logic [7:0] idx;
    logic       in_range;

    always_comb
    begin
        sum      = {1'b0, 7'(cur)} + {entry.value[6], entry.value};
        idx      = entry.value[6] ? sum : {1'b0, entry.value};
        in_range = !idx[7] && (idx < 8'(dss_pkg::DEPTH));
        met      = !entry.present || !in_range || !fail_marks[idx[dss_pkg::IDX_W-1:0]];
    end

endmodule
`default_nettype wire

[hdl/dependent_step_sequencer.sv]
// dependent_step_sequencer: top level; sequencer, step state and result register.
// Depends on dss_pkg, dss_store, dss_req_unit.
//
//  channel | dir | beat fields
//  s_*     | in  | tuser: mode; tdata: requirement_present, requirement_value, target_index
//  m_*     | out | tdata: step_index; tuser: result_kind; tlast: last_of_run
//
// Each beat is accepted in ST_IDLE and executed in ST_EXEC.
// A start, or a finished/failed beat with a step to follow, then runs the skip chain
// in ST_CHAIN, one step at a time through the shared requirement unit, for a chain
// of up to DEPTH steps.
// A full result register stalls execution until m_tready.
// Reset clears the fail marks, cur and count and sets nxt to 1; the table needs no reset.
`default_nettype none
module dependent_step_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // requirement_present[0], requirement_value[7:1],
                                       // target_index[13:8]
    input  wire logic [2:0]  s_tuser,  // mode[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // step_index[5:0]
    output logic [1:0]       m_tuser,  // result_kind[1:0]
    output logic             m_tlast
);

    localparam int IW = dss_pkg::IDX_W;
    localparam int CW = dss_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_CHAIN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [CW-1:0] nxt_reg, nxt_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [2:0]    mode_reg;
    logic          pres_reg;
    logic [6:0]    val_reg;
    logic [5:0]    tgt_reg;

    logic          ov_reg;
    logic [5:0]    oidx_reg;
    logic [1:0]    okind_reg;
    logic          olast_reg;

    logic          emit;
    logic [1:0]    e_kind;
    logic          e_last;
    logic          out_free;
    logic [CW-1:0] cur_ext;
    logic [CW-1:0] cur_inc;

    dss_pkg::tbl_wr_t    tbl_wr;
    dss_pkg::fail_wr_t   fail_wr;
    dss_pkg::req_entry_t rd_entry;
    logic [dss_pkg::DEPTH-1:0] fail_marks;
    logic                met;

    dss_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .tbl_wr     (tbl_wr),
        .fail_wr    (fail_wr),
        .rd_addr    (cur_reg),
        .rd_entry   (rd_entry),
        .fail_marks (fail_marks)
    );

    dss_req_unit u_req (
        .entry      (rd_entry),
        .cur        (cur_reg),
        .fail_marks (fail_marks),
        .met        (met)
    );

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cur_ext  = CW'(cur_reg);
    assign cur_inc  = cur_ext + CW'(1);

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        e_kind       = dss_pkg::KIND_ACK;
        e_last       = 1'b1;
        tbl_wr.en    = 1'b0;
        tbl_wr.addr  = cnt_reg[IW-1:0];
        tbl_wr.data  = {pres_reg, val_reg};
        fail_wr.en   = 1'b0;
        fail_wr.addr = cur_reg;
        fail_wr.mark = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    case (mode_reg)
                        dss_pkg::MODE_APPEND:
                        begin
                            if (cnt_reg >= CW'(dss_pkg::DEPTH))
                            begin
                                e_kind = dss_pkg::KIND_ERROR;
                            end
                            else
                            begin
                                tbl_wr.en    = 1'b1;
                                fail_wr.en   = 1'b1;
                                fail_wr.addr = cnt_reg[IW-1:0];
                                fail_wr.mark = 1'b0;
                                cnt_next     = cnt_reg + CW'(1);
                            end
                        end
                        dss_pkg::MODE_START:
                        begin
                            if (cur_ext >= cnt_reg)
                            begin
                                e_kind = dss_pkg::KIND_ERROR;
                            end
                            else
                            begin
                                emit       = 1'b0;
                                state_next = ST_CHAIN;
                            end
                        end
                        dss_pkg::MODE_DONE, dss_pkg::MODE_FAIL:
                        begin
                            fail_wr.en   = 1'b1;
                            fail_wr.mark = (mode_reg == dss_pkg::MODE_FAIL);
                            if (nxt_reg < cnt_reg)
                            begin
                                cur_next   = nxt_reg[IW-1:0];
                                emit       = 1'b0;
                                state_next = ST_CHAIN;
                            end
                        end
                        dss_pkg::MODE_SETNXT:
                        begin
                            if (7'(tgt_reg) >= 7'(dss_pkg::DEPTH))
                            begin
                                e_kind = dss_pkg::KIND_ERROR;
                            end
                            else
                            begin
                                nxt_next = CW'(tgt_reg);
                            end
                        end
                        default:
                        begin
                            e_kind = dss_pkg::KIND_ACK;
                        end
                    endcase
                end
            end
            ST_CHAIN:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    nxt_next = cur_inc;
                    if (met)
                    begin
                        e_kind     = dss_pkg::KIND_START;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_kind     = dss_pkg::KIND_SKIP;
                        fail_wr.en = 1'b1;
                        if (cur_inc < cnt_reg)
                        begin
                            e_last   = 1'b0;
                            cur_next = cur_inc[IW-1:0];
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            nxt_reg   <= CW'(1);
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            nxt_reg   <= nxt_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg <= s_tuser;
            pres_reg <= s_tdata[0];
            val_reg  <= s_tdata[7:1];
            tgt_reg  <= s_tdata[13:8];
        end
        if (emit)
        begin
            oidx_reg  <= 6'(cur_reg);
            okind_reg <= e_kind;
            olast_reg <= e_last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, oidx_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

[hdl/dss_checker.sv]
// dss_assertions: port-level assertions for dependent_step_sequencer, with bind.
// Depends on dss_pkg; attaches to the top level.
`default_nettype none
module dss_assertions (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    input  wire logic [1:0] m_tuser,
    input  wire logic       m_tlast
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready straight after an accepted beat");

    a_single_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == dss_pkg::KIND_START || m_tuser == dss_pkg::KIND_ACK
                     || m_tuser == dss_pkg::KIND_ERROR) |-> m_tlast)
        else $error("start, ack or error beat without tlast");

    a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tlast)
        else $error("ready while a run is unfinished");

endmodule

bind dependent_step_sequencer dss_assertions u_dss_assertions (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

[tb/sv/dss_checker.sv]
// dss_checker: watches both stream channels of dependent_step_sequencer, predicts the
// results of every accepted input beat and compares them with the output beats.
// Depends on dss_pkg.
module dss_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,  // requirement_present[0], requirement_value[7:1],
                                       // target_index[13:8]
    input  wire logic [2:0]  s_tuser,  // mode[2:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,  // step_index[5:0]
    input  wire logic [1:0]  m_tuser,  // result_kind[1:0]
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               outstanding,
    output int               results_checked
);

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] step;
        logic       last;
    } step_result_t;

    step_result_t step_results_q[$];

    dss_pkg::req_entry_t req_tbl [dss_pkg::DEPTH];
    logic                fail_mark [dss_pkg::DEPTH];
    int                  cur_step;
    int                  nxt_step;
    int                  step_cnt;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic push_result(input logic [1:0] kind, input int step);
        step_result_t r;
        r.kind = kind;
        r.step = step[5:0];
        r.last = 1'b0;
        step_results_q.push_back(r);
    endtask

    function automatic bit requirement_satisfied();
        dss_pkg::req_entry_t e;
        int                  v;
        int                  idx;
        if (cur_step >= dss_pkg::DEPTH)
            return 1'b1;
        e = req_tbl[cur_step];
        if (!e.present)
            return 1'b1;
        v   = $signed(e.value);
        idx = (v >= 0) ? v : cur_step + v;
        if (idx < 0 || idx >= dss_pkg::DEPTH)
            return 1'b1;
        return !fail_mark[idx];
    endfunction

    // start the current step, skipping steps whose requirement failed
    task automatic walk_skip_chain();
        bit stop;
        stop = 1'b0;
        while (!stop)
        begin
            nxt_step = cur_step + 1;
            if (requirement_satisfied())
            begin
                push_result(dss_pkg::KIND_START, cur_step);
                stop = 1'b1;
            end
            else
            begin
                if (cur_step < dss_pkg::DEPTH)
                    fail_mark[cur_step] = 1'b1;
                push_result(dss_pkg::KIND_SKIP, cur_step);
                if (nxt_step < step_cnt)
                    cur_step = nxt_step;
                else
                    stop = 1'b1;
            end
        end
    endtask

    task automatic predict_step_results(input logic [2:0] mode, input logic [15:0] data);
        logic         present;
        logic [6:0]   value;
        logic [5:0]   target;
        step_result_t r;
        present = data[0];
        value   = data[7:1];
        target  = data[13:8];
        case (mode)
            dss_pkg::MODE_APPEND:
            begin
                if (step_cnt >= dss_pkg::DEPTH)
                    push_result(dss_pkg::KIND_ERROR, cur_step);
                else
                begin
                    req_tbl[step_cnt]   = '{present: present, value: value};
                    fail_mark[step_cnt] = 1'b0;
                    step_cnt++;
                    push_result(dss_pkg::KIND_ACK, cur_step);
                end
            end
            dss_pkg::MODE_START:
            begin
                if (cur_step >= step_cnt)
                    push_result(dss_pkg::KIND_ERROR, cur_step);
                else
                    walk_skip_chain();
            end
            dss_pkg::MODE_DONE, dss_pkg::MODE_FAIL:
            begin
                if (cur_step < dss_pkg::DEPTH)
                    fail_mark[cur_step] = (mode == dss_pkg::MODE_FAIL);
                if (nxt_step < step_cnt)
                begin
                    cur_step = nxt_step;
                    walk_skip_chain();
                end
                else
                    push_result(dss_pkg::KIND_ACK, cur_step);
            end
            dss_pkg::MODE_SETNXT:
            begin
                if (target >= dss_pkg::DEPTH)
                    push_result(dss_pkg::KIND_ERROR, cur_step);
                else
                begin
                    nxt_step = int'(target);
                    push_result(dss_pkg::KIND_ACK, cur_step);
                end
            end
            default:
                push_result(dss_pkg::KIND_ACK, cur_step);
        endcase
        r = step_results_q.pop_back();
        r.last = 1'b1;
        step_results_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        step_result_t exp_r;
        if (!rst_n)
        begin
            step_results_q.delete();
            for (int i = 0; i < dss_pkg::DEPTH; i++)
            begin
                req_tbl[i]   = '0;
                fail_mark[i] = 1'b0;
            end
            cur_step        = 0;
            nxt_step        = 1;
            step_cnt        = 0;
            mismatches      = 0;
            results_checked = 0;
            outstanding     = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_step_results(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (step_results_q.size() == 0)
                    report_mismatch($sformatf("unexpected beat kind %0d step %0d last %0b",
                                              m_tuser, m_tdata, m_tlast));
                else
                begin
                    exp_r = step_results_q.pop_front();
                    if (m_tuser !== exp_r.kind)
                        report_mismatch($sformatf("result_kind %0d, expected %0d",
                                                  m_tuser, exp_r.kind));
                    if (m_tdata !== {2'b00, exp_r.step})
                        report_mismatch($sformatf("step_index %0d, expected %0d",
                                                  m_tdata, exp_r.step));
                    if (m_tlast !== exp_r.last)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                                  m_tlast, exp_r.last));
                end
            end
            outstanding = step_results_q.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// tb: stimulus and verdict for dependent_step_sequencer; directed step sequences,
// then random event streams under three idling regimes.
// Depends on dss_pkg, dependent_step_sequencer and dss_checker.
module tb;

    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
    localparam int         RANDOM_PER_PHASE  = 96;
    localparam int         CYCLE_LIMIT       = 200000;
    localparam int         TAIL_CYCLES       = 48;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int results_checked;
    int send_idle_pct = 23;
    int recv_idle_pct = 51;
    int beats_sent    = 0;
    int cycle_count   = 0;

    dependent_step_sequencer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dss_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycle_count);
            $display("dependent_step_sequencer regression: fail");
            $finish;
        end
    end

    // beat[2:0] is the mode (tuser), beat[18:3] the tdata word
    function automatic logic [18:0] pack_beat(input logic [2:0] mode, input logic present,
                                              input int req_val, input int target);
        return {2'b00, target[5:0], req_val[6:0], present, mode};
    endfunction

    // called at a falling edge, returns at a falling edge after the beat is taken
    task automatic send_beat(input logic [18:0] beat);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= beat[2:0];
        s_tdata  <= beat[18:3];
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
        @(negedge clk);
    endtask

    function automatic int fill_requirement();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return -$urandom_range(1, 4);
        else if (r < 80)
            return $urandom_range(0, dss_pkg::DEPTH - 1);
        return $urandom_range(0, 127);
    endfunction

    function automatic logic [18:0] random_event();
        int         r;
        logic [2:0] mode;
        int         target;
        r      = $urandom_range(0, 99);
        target = $urandom_range(0, 63);
        if (r < 14)
            mode = dss_pkg::MODE_START;
        else if (r < 38)
            mode = dss_pkg::MODE_DONE;
        else if (r < 66)
            mode = dss_pkg::MODE_FAIL;
        else if (r < 86)
        begin
            mode = dss_pkg::MODE_SETNXT;
            if ($urandom_range(0, 99) < 80)
                target = $urandom_range(0, dss_pkg::DEPTH - 1);
        end
        else if (r < 91)
            mode = dss_pkg::MODE_APPEND;
        else
            mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        return pack_beat(mode, 1'($urandom_range(0, 1)), $urandom_range(0, 127), target);
    endfunction

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table: start beyond table, unused modes, set-next out of range
        send_beat(pack_beat(dss_pkg::MODE_START, 1'b0, 0, 0));
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
            send_beat(pack_beat(3'(m), 1'b1, 127, 63));
        send_beat(pack_beat(dss_pkg::MODE_SETNXT, 1'b0, 0, 63));
        send_beat(pack_beat(dss_pkg::MODE_SETNXT, 1'b0, 0, dss_pkg::DEPTH));

        // steps 0..6: none, abs 0, -1, abs 63 (outside), -64 (outside), -1, -1
        send_beat(pack_beat(dss_pkg::MODE_APPEND, 1'b0, 0, 0));
        send_beat(pack_beat(dss_pkg::MODE_APPEND, 1'b1, 0, 0));
        send_beat(pack_beat(dss_pkg::MODE_APPEND, 1'b1, -1, 0));
        send_beat(pack_beat(dss_pkg::MODE_APPEND, 1'b1, 63, 0));
        send_beat(pack_beat(dss_pkg::MODE_APPEND, 1'b1, -64, 0));
        send_beat(pack_beat(dss_pkg::MODE_APPEND, 1'b1, -1, 0));
        send_beat(pack_beat(dss_pkg::MODE_APPEND, 1'b1, -1, 0));

        // failure of step 0 skips 1 and 2; skip chain ending at the last step
        send_beat(pack_beat(dss_pkg::MODE_START, 1'b0, 0, 0));
        send_beat(pack_beat(dss_pkg::MODE_FAIL, 1'b0, 0, 0));
        send_beat(pack_beat(dss_pkg::MODE_SETNXT, 1'b0, 0, 5));
        send_beat(pack_beat(dss_pkg::MODE_FAIL, 1'b0, 0, 0));
        send_beat(pack_beat(dss_pkg::MODE_FAIL, 1'b0, 0, 0));
        send_beat(pack_beat(dss_pkg::MODE_DONE, 1'b0, 0, 0));
        send_beat(pack_beat(dss_pkg::MODE_START, 1'b0, 0, 0));
        send_beat(pack_beat(dss_pkg::MODE_SETNXT, 1'b0, 0, 0));

        // fill the table, then one append past full
        for (int i = 7; i < dss_pkg::DEPTH; i++)
            send_beat(pack_beat(dss_pkg::MODE_APPEND, $urandom_range(0, 3) != 0,
                                fill_requirement(), $urandom_range(0, 63)));
        send_beat(pack_beat(dss_pkg::MODE_APPEND, 1'b1, -1, 0));

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_beat(random_event());
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("sent %0d input beats (directed sequences, then three idling regimes)",
                 beats_sent);
        $display("checked %0d result beats, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("dependent_step_sequencer regression: pass");
        else
            $display("dependent_step_sequencer regression: fail");
        $finish;
    end

endmodule

[files.f]
hdl/dss_pkg.sv
hdl/dss_store.sv
hdl/dss_req_unit.sv
hdl/dependent_step_sequencer.sv
hdl/dss_checker.sv
tb/sv/dss_checker.sv
tb/sv/tb.sv
